[src/sorted_key_value_upsert_macros.svh]
// Assertion macros used by the checker of the upsert table.
`ifndef SORTED_KEY_VALUE_UPSERT_MACROS_SVH
`define SORTED_KEY_VALUE_UPSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SKVU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_value_upsert: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SKVU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_value_upsert: check failed");

`endif

[src/skvu_pkg.sv]
package skvu_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_CARRY  = 2'd1,
    MODE_DONE   = 2'd2
  } mode_t;

  // Travels from cell to cell, one cell per cycle.
  typedef struct packed {
    logic               vld;
    mode_t              mode;
    logic signed [31:0] key;
    logic signed [31:0] val;
    status_t            status;
  } wave_t;

endpackage

[src/skvu_cell.sv]
module skvu_cell import skvu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  full,
  input  wave_t wave_in,
  output wave_t wave_out
);

  logic               vld_r, vld_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] val_r, val_nxt;
  wave_t              wave_r, wave_nxt;

  always_comb begin
    vld_nxt  = vld_r;
    key_nxt  = key_r;
    val_nxt  = val_r;
    wave_nxt = wave_in;
    if (wave_in.vld) begin
      unique case (wave_in.mode)
        MODE_SEARCH: begin
          priority if (vld_r && (key_r < wave_in.key)) begin
            // pass on unchanged
          end else if (vld_r && (key_r == wave_in.key)) begin
            val_nxt         = wave_in.val;
            wave_nxt.mode   = MODE_DONE;
            wave_nxt.status = ST_UPDATED;
          end else if (full) begin
            wave_nxt.mode   = MODE_DONE;
            wave_nxt.status = ST_DROPPED;
          end else begin
            // take the new pair, push the old one up the row
            vld_nxt         = 1'b1;
            key_nxt         = wave_in.key;
            val_nxt         = wave_in.val;
            wave_nxt.key    = key_r;
            wave_nxt.val    = val_r;
            wave_nxt.mode   = vld_r ? MODE_CARRY : MODE_DONE;
            wave_nxt.status = ST_INSERTED;
          end
        end
        MODE_CARRY: begin
          vld_nxt       = 1'b1;
          key_nxt       = wave_in.key;
          val_nxt       = wave_in.val;
          wave_nxt.key  = key_r;
          wave_nxt.val  = val_r;
          wave_nxt.mode = vld_r ? MODE_CARRY : MODE_DONE;
        end
        MODE_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      wave_r.vld <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      wave_r.vld <= wave_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    val_r         <= val_nxt;
    wave_r.mode   <= wave_nxt.mode;
    wave_r.key    <= wave_nxt.key;
    wave_r.val    <= wave_nxt.val;
    wave_r.status <= wave_nxt.status;
  end

  assign wave_out = wave_r;

endmodule

[src/sorted_key_value_upsert.sv]
// Channel   Ports                                   Handshake
// input     in_entry_key, in_entry_value            start high and busy low
// result    out_echo_key, out_upsert_status         out_valid, one cycle
//
// An item runs through a row of CAPACITY cells, one cell per cycle, behind the
// head register; busy drops in the cycle after the result strobes, so a new
// item is taken only once the last one has left the row.
// Reset (rst_n low at a clock edge) empties the table at once.
// The receiver cannot stall: out_valid lasts exactly one cycle.
module sorted_key_value_upsert import skvu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_entry_key,
  input  logic signed [31:0] in_entry_value,
  output logic               out_valid,
  output logic signed [31:0] out_echo_key,
  output logic [1:0]         out_upsert_status
);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] echo_r;
  wave_t              head_r;
  wave_t              chain [CAPACITY+1];
  logic               accept;
  logic               full;

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign chain[0] = head_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .full     (full),
      .wave_in  (chain[i]),
      .wave_out (chain[i+1])
    );
  end

  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (chain[CAPACITY].vld) begin
      busy_nxt = 1'b0;
    end
    if (chain[CAPACITY].vld && (chain[CAPACITY].status == ST_INSERTED)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      count_r    <= '0;
      head_r.vld <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      count_r    <= count_nxt;
      head_r.vld <= accept;
    end
  end

  // A search that leaves the row unresolved found a full table: start as dropped.
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_r        <= in_entry_key;
      head_r.mode   <= MODE_SEARCH;
      head_r.key    <= in_entry_key;
      head_r.val    <= in_entry_value;
      head_r.status <= ST_DROPPED;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = chain[CAPACITY].vld;
  assign out_echo_key      = echo_r;
  assign out_upsert_status = chain[CAPACITY].status;

endmodule

[src/skvu_checker.sv]
`include "sorted_key_value_upsert_macros.svh"

module skvu_checker import skvu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_entry_key,
  input logic               out_valid,
  input logic signed [31:0] out_echo_key,
  input logic [1:0]         out_upsert_status
);

  localparam int LAT = CAPACITY + 1;

  logic accept;

  assign accept = start && !busy;

  `SKVU_ASSERT_NOW(a_status_code, out_valid, out_upsert_status <= ST_DROPPED)
  `SKVU_ASSERT_NOW(a_result_in_flight, out_valid, busy)
  `SKVU_ASSERT_NEXT(a_accept_busy, accept, busy)
  `SKVU_ASSERT_NEXT(a_result_pulse, out_valid, !out_valid && !busy)
  `SKVU_ASSERT_NOW(a_echo_lat, accept, ##LAT (out_valid && out_echo_key == $past(in_entry_key, LAT)))

endmodule

bind sorted_key_value_upsert skvu_checker u_skvu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_entry_key      (in_entry_key),
  .out_valid         (out_valid),
  .out_echo_key      (out_echo_key),
  .out_upsert_status (out_upsert_status)
);
